@@ rtl/nrmc_pkg.sv @@
package nrmc_pkg;

    // fraction digits kept for each scaled field
    localparam int unsigned TIME_FRAC_DIGITS  = 2;
    localparam int unsigned POS_FRAC_DIGITS   = 4;
    localparam int unsigned SPEED_FRAC_DIGITS = 2;

    // widest accumulator (longitude) sets the shared datapath width
    localparam int ACC_W   = 28;
    localparam int POW10_W = 17;

    localparam int TIME_W  = 25;
    localparam int LAT_W   = 27;
    localparam int LON_W   = 28;
    localparam int SPEED_W = 24;
    localparam int DATE_W  = 19;

    typedef logic [ACC_W-1:0] t_acc;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIELDS,
        PH_CHK1,
        PH_CHK2
    } t_phase;

    // field numbers within the sentence
    localparam logic [3:0] FLD_TIME   = 4'd1;
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LAT    = 4'd3;
    localparam logic [3:0] FLD_LON    = 4'd5;
    localparam logic [3:0] FLD_SPEED  = 4'd7;
    localparam logic [3:0] FLD_DATE   = 4'd9;
    localparam logic [3:0] FLD_MAX    = 4'd15;

    localparam logic [2:0] HDR_LEN   = 3'd5;
    localparam logic [2:0] DONE_MARK = 3'd7;
    localparam logic [1:0] CHARS_MAX = 2'd3;

    // ascii codes
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UC     = 8'h43;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_UG     = 8'h47;
    localparam logic [7:0] CH_UM     = 8'h4D;
    localparam logic [7:0] CH_UP     = 8'h50;
    localparam logic [7:0] CH_UR     = 8'h52;

    localparam t_acc MAX_TIME  = 28'd24000000;
    localparam t_acc MAX_LAT   = 28'd90000000;
    localparam t_acc MAX_LON   = 28'd180000000;
    localparam t_acc MAX_SPEED = 28'd9999999;
    localparam t_acc MAX_DATE  = 28'd311299;

    typedef struct packed {
        logic [TIME_W-1:0]  time_acc;
        logic [LAT_W-1:0]   lat_acc;
        logic [LON_W-1:0]   lon_acc;
        logic [SPEED_W-1:0] speed_acc;
        logic [DATE_W-1:0]  date_acc;
    } t_accs;

    typedef struct packed {
        logic       is_num;
        logic [2:0] frac;
        t_acc       digit_val;
        t_acc       fin_val;
    } t_num_res;

    typedef struct packed {
        logic               fix_valid;
        logic               checksum_ok;
        logic [TIME_W-1:0]  utc_time_hundredths;
        logic [LAT_W-1:0]   latitude_scaled;
        logic [LON_W-1:0]   longitude_scaled;
        logic [SPEED_W-1:0] speed_hundredths;
        logic [DATE_W-1:0]  date_ddmmyy;
    } t_result;

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = CH_UG;
            3'd1:    ch = CH_UP;
            3'd2:    ch = CH_UR;
            3'd3:    ch = CH_UM;
            3'd4:    ch = CH_UC;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic field_is_num(input logic [3:0] fld);
        return (fld == FLD_TIME) || (fld == FLD_LAT) || (fld == FLD_LON) ||
               (fld == FLD_SPEED) || (fld == FLD_DATE);
    endfunction

    function automatic logic [2:0] field_frac(input logic [3:0] fld);
        logic [2:0] f;
        case (fld)
            FLD_TIME:  f = 3'(TIME_FRAC_DIGITS);
            FLD_LAT:   f = 3'(POS_FRAC_DIGITS);
            FLD_LON:   f = 3'(POS_FRAC_DIGITS);
            FLD_SPEED: f = 3'(SPEED_FRAC_DIGITS);
            default:   f = 3'd0;
        endcase
        return f;
    endfunction

    function automatic t_acc field_limit(input logic [3:0] fld);
        t_acc lim;
        case (fld)
            FLD_TIME:  lim = MAX_TIME;
            FLD_LAT:   lim = MAX_LAT;
            FLD_LON:   lim = MAX_LON;
            FLD_SPEED: lim = MAX_SPEED;
            FLD_DATE:  lim = MAX_DATE;
            default:   lim = '0;
        endcase
        return lim;
    endfunction

    function automatic logic [POW10_W-1:0] pow10(input logic [2:0] n);
        logic [POW10_W-1:0] p;
        case (n)
            3'd0:    p = 17'd1;
            3'd1:    p = 17'd10;
            3'd2:    p = 17'd100;
            3'd3:    p = 17'd1000;
            3'd4:    p = 17'd10000;
            3'd5:    p = 17'd100000;
            default: p = 17'd1;
        endcase
        return p;
    endfunction

    // '1'-'9' and 'A'-'F' decode, everything else reads as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        if (c >= CH_ONE && c <= CH_NINE) begin
            v = c[3:0];
        end else if (c >= CH_UA && c <= CH_UF) begin
            v = c[3:0] + 4'd9;
        end else begin
            v = 4'd0;
        end
        return v;
    endfunction

endpackage

@@ rtl/nmea_rmc_sentence_parser_core.sv @@
// RMC sentence parser: takes one received character per transfer on the input
// channel and scans the stream for the "GPRMC" header. From the header's 'G' up
// to '*' every byte is XORed into a running checksum; fields are split at commas
// and time, latitude, longitude, speed and date are accumulated as scaled
// integers (extra fraction digits truncated, missing ones padded with zeros,
// values saturating at their range). One result transfer is produced at the
// second character after '*', or at CR/LF when no '*' came (then checksum_ok is
// 0). fix_valid needs status "A" and a matching checksum; otherwise the five
// value fields are zero. Rate: one character per cycle while the input is not
// stalled. A character in the input register goes through a single pass of
// compare and multiply-accumulate logic that updates the parse state; a character
// that ends a sentence loads the result into the output register. The input side
// keeps flowing while a result waits, and stalls only when a character that
// ends a sentence meets a result register that is still full and not taken.
module nmea_rmc_sentence_parser_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // character channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_rx_byte,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_fix_valid,
    output logic                       o_checksum_ok,
    output logic [nrmc_pkg::TIME_W-1:0]  o_utc_time_hundredths,
    output logic [nrmc_pkg::LAT_W-1:0]   o_latitude_scaled,
    output logic [nrmc_pkg::LON_W-1:0]   o_longitude_scaled,
    output logic [nrmc_pkg::SPEED_W-1:0] o_speed_hundredths,
    output logic [nrmc_pkg::DATE_W-1:0]  o_date_ddmmyy
);
    import nrmc_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // parse state
    t_phase     r_phase,     n_phase;
    logic [2:0] r_hdr_pos,   n_hdr_pos;
    logic [3:0] r_field_num, n_field_num;
    logic [1:0] r_chars,     n_chars;
    logic [7:0] r_xor,       n_xor;
    logic       r_status,    n_status;
    logic [2:0] r_frac_cnt,  n_frac_cnt;
    logic       r_point,     n_point;
    logic [3:0] r_chk_hi,    n_chk_hi;
    t_accs      r_accs,      n_accs;

    logic       w_adv;
    logic       w_out_free;
    logic       w_emit;
    logic       w_ok;
    logic       w_finish;
    logic       w_start;
    logic       w_clr_accs;
    logic       w_acc_wr;
    t_acc       w_acc_val;
    logic       w_is_digit;
    t_num_res   w_num;
    t_result    w_result;
    t_result    w_out_data;

    // the character in the input register is consumed unless it ends a sentence
    // while the result register is still occupied
    assign w_adv   = r_in_valid && (w_out_free || !w_emit);
    assign o_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // shared scaling / multiply-accumulate datapath for the current field
    nrmc_num_unit u_num (
        .i_accs     (r_accs),
        .i_field    (r_field_num),
        .i_char     (r_in_byte),
        .i_frac_cnt (r_frac_cnt),
        .o_res      (w_num)
    );

    assign w_is_digit = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);

    always_comb begin
        n_phase     = r_phase;
        n_hdr_pos   = r_hdr_pos;
        n_field_num = r_field_num;
        n_chars     = r_chars;
        n_xor       = r_xor;
        n_status    = r_status;
        n_frac_cnt  = r_frac_cnt;
        n_point     = r_point;
        n_chk_hi    = r_chk_hi;
        n_accs      = r_accs;
        w_emit      = 1'b0;
        w_ok        = 1'b0;
        w_finish    = 1'b0;
        w_start     = 1'b0;
        w_clr_accs  = 1'b0;
        w_acc_wr    = 1'b0;
        w_acc_val   = w_num.digit_val;

        case (r_phase)
            PH_IDLE: begin
                // header search; a stray 'G' restarts the match
                if (r_hdr_pos < HDR_LEN && r_in_byte == hdr_char(r_hdr_pos)) begin
                    n_xor     = (r_hdr_pos == 3'd0) ? r_in_byte : (r_xor ^ r_in_byte);
                    n_hdr_pos = r_hdr_pos + 3'd1;
                end else if (r_in_byte == CH_UG) begin
                    n_xor     = r_in_byte;
                    n_hdr_pos = 3'd1;
                end else begin
                    n_hdr_pos = 3'd0;
                end
                if (n_hdr_pos >= HDR_LEN) begin
                    n_phase     = PH_FIELDS;
                    n_hdr_pos   = 3'd0;
                    n_field_num = 4'd0;
                    n_status    = 1'b0;
                    w_clr_accs  = 1'b1;
                    w_start     = 1'b1;
                end
            end
            PH_FIELDS: begin
                if (r_in_byte == CH_DOLLAR) begin
                    // new sentence start: drop this one silently
                    n_phase   = PH_IDLE;
                    n_hdr_pos = 3'd0;
                end else if (r_in_byte == CH_STAR) begin
                    w_finish = 1'b1;
                    n_phase  = PH_CHK1;
                end else if (r_in_byte == CH_CR || r_in_byte == CH_LF) begin
                    // no checksum came, report as a failed checksum
                    w_finish  = 1'b1;
                    w_emit    = 1'b1;
                    n_phase   = PH_IDLE;
                    n_hdr_pos = 3'd0;
                end else begin
                    n_xor = r_xor ^ r_in_byte;
                    if (r_in_byte == CH_COMMA) begin
                        w_finish = 1'b1;
                        w_start  = 1'b1;
                        if (r_field_num != FLD_MAX) begin
                            n_field_num = r_field_num + 4'd1;
                        end
                    end else if (r_field_num == FLD_STATUS) begin
                        n_status = (r_chars == 2'd0) && (r_in_byte == CH_UA);
                        if (r_chars != CHARS_MAX) begin
                            n_chars = r_chars + 2'd1;
                        end
                    end else if (w_num.is_num && r_frac_cnt != DONE_MARK) begin
                        if (w_is_digit) begin
                            if (!r_point) begin
                                w_acc_wr = 1'b1;
                            end else if (r_frac_cnt < w_num.frac) begin
                                w_acc_wr   = 1'b1;
                                n_frac_cnt = r_frac_cnt + 3'd1;
                            end
                        end else if (r_in_byte == CH_DOT && !r_point) begin
                            n_point = 1'b1;
                        end else begin
                            // conversion stops at any other character
                            w_finish = 1'b1;
                        end
                    end
                end
            end
            PH_CHK1: begin
                n_chk_hi = hex_value(r_in_byte);
                n_phase  = PH_CHK2;
            end
            PH_CHK2: begin
                w_emit    = 1'b1;
                w_ok      = ({r_chk_hi, hex_value(r_in_byte)} == r_xor);
                n_phase   = PH_IDLE;
                n_hdr_pos = 3'd0;
            end
            default: begin
                n_phase   = PH_IDLE;
                n_hdr_pos = 3'd0;
            end
        endcase

        // close a numeric field: pad the fraction digits that never came
        if (w_finish && w_num.is_num && r_frac_cnt != DONE_MARK) begin
            w_acc_wr   = 1'b1;
            w_acc_val  = w_num.fin_val;
            n_frac_cnt = DONE_MARK;
        end

        if (w_start) begin
            n_chars    = 2'd0;
            n_frac_cnt = 3'd0;
            n_point    = 1'b0;
        end

        if (w_clr_accs) begin
            n_accs = '0;
        end else if (w_acc_wr) begin
            case (r_field_num)
                FLD_TIME:  n_accs.time_acc  = w_acc_val[TIME_W-1:0];
                FLD_LAT:   n_accs.lat_acc   = w_acc_val[LAT_W-1:0];
                FLD_LON:   n_accs.lon_acc   = w_acc_val[LON_W-1:0];
                FLD_SPEED: n_accs.speed_acc = w_acc_val[SPEED_W-1:0];
                FLD_DATE:  n_accs.date_acc  = w_acc_val[DATE_W-1:0];
                default:   n_accs           = r_accs;
            endcase
        end
    end

    // result is built from the post-update status and accumulator values
    always_comb begin
        w_result.fix_valid           = w_ok && n_status;
        w_result.checksum_ok         = w_ok;
        w_result.utc_time_hundredths = '0;
        w_result.latitude_scaled     = '0;
        w_result.longitude_scaled    = '0;
        w_result.speed_hundredths    = '0;
        w_result.date_ddmmyy         = '0;
        if (w_ok && n_status) begin
            w_result.utc_time_hundredths = n_accs.time_acc;
            w_result.latitude_scaled     = n_accs.lat_acc;
            w_result.longitude_scaled    = n_accs.lon_acc;
            w_result.speed_hundredths    = n_accs.speed_acc;
            w_result.date_ddmmyy         = n_accs.date_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_hdr_pos <= 3'd0;
        end else if (w_adv) begin
            r_phase   <= n_phase;
            r_hdr_pos <= n_hdr_pos;
        end
    end

    // everything here is set by the header search, or by the first checksum character, before it is ever read
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_field_num <= n_field_num;
            r_chars     <= n_chars;
            r_xor       <= n_xor;
            r_status    <= n_status;
            r_frac_cnt  <= n_frac_cnt;
            r_point     <= n_point;
            r_chk_hi    <= n_chk_hi;
            r_accs      <= n_accs;
        end
    end

    nrmc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_adv && w_emit),
        .i_data  (w_result),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_data  (w_out_data),
        .o_free  (w_out_free)
    );

    assign o_fix_valid           = w_out_data.fix_valid;
    assign o_checksum_ok         = w_out_data.checksum_ok;
    assign o_utc_time_hundredths = w_out_data.utc_time_hundredths;
    assign o_latitude_scaled     = w_out_data.latitude_scaled;
    assign o_longitude_scaled    = w_out_data.longitude_scaled;
    assign o_speed_hundredths    = w_out_data.speed_hundredths;
    assign o_date_ddmmyy         = w_out_data.date_ddmmyy;

    // a fix is never reported without a good checksum
    a_fix_needs_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fix_valid |-> o_checksum_ok)
        else $error("fix reported with bad checksum");

    // values are zero whenever there is no fix
    a_zero_no_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_fix_valid |-> (o_utc_time_hundredths == '0) &&
            (o_latitude_scaled == '0) && (o_longitude_scaled == '0) &&
            (o_speed_hundredths == '0) && (o_date_ddmmyy == '0))
        else $error("nonzero value without fix");

    // header position only moves while searching for a header
    a_hdr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> r_hdr_pos == 3'd0)
        else $error("header position active outside header search");

    // saturation keeps reported values within range; time, longitude and date are checked here
    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_utc_time_hundredths <= MAX_TIME[TIME_W-1:0]) &&
            (o_longitude_scaled <= MAX_LON[LON_W-1:0]) &&
            (o_date_ddmmyy <= MAX_DATE[DATE_W-1:0]))
        else $error("reported value above its range");

endmodule

@@ rtl/nrmc_num_unit.sv @@
module nrmc_num_unit (
    input  nrmc_pkg::t_accs    i_accs,
    input  logic [3:0]         i_field,
    input  logic [7:0]         i_char,
    input  logic [2:0]         i_frac_cnt,
    output nrmc_pkg::t_num_res o_res
);
    import nrmc_pkg::*;

    t_acc                       w_acc;
    t_acc                       w_limit;
    logic [ACC_W+3:0]           w_mul10;
    logic [2:0]                 w_frac;
    logic [2:0]                 w_need;
    logic [ACC_W+POW10_W-1:0]   w_scaled;

    // pick the accumulator of the current field
    always_comb begin
        case (i_field)
            FLD_TIME:  w_acc = ACC_W'(i_accs.time_acc);
            FLD_LAT:   w_acc = ACC_W'(i_accs.lat_acc);
            FLD_LON:   w_acc = ACC_W'(i_accs.lon_acc);
            FLD_SPEED: w_acc = ACC_W'(i_accs.speed_acc);
            FLD_DATE:  w_acc = ACC_W'(i_accs.date_acc);
            default:   w_acc = '0;
        endcase
    end

    assign w_limit = field_limit(i_field);
    assign w_frac  = field_frac(i_field);

    // acc * 10 + digit as two shifts and adds
    assign w_mul10 = ({4'b0, w_acc} << 3) + ({4'b0, w_acc} << 1) +
                     {{ACC_W{1'b0}}, i_char[3:0]};

    // pad missing fraction digits in one multiply
    assign w_need   = w_frac - i_frac_cnt;
    assign w_scaled = {{POW10_W{1'b0}}, w_acc} * {{ACC_W{1'b0}}, pow10(w_need)};

    always_comb begin
        o_res.is_num    = field_is_num(i_field);
        o_res.frac      = w_frac;
        o_res.digit_val = (w_mul10 > {4'b0, w_limit}) ? w_limit : w_mul10[ACC_W-1:0];
        o_res.fin_val   = (w_scaled > {{POW10_W{1'b0}}, w_limit}) ? w_limit
                                                                   : w_scaled[ACC_W-1:0];
    end

endmodule

@@ rtl/nrmc_out_stage.sv @@
module nrmc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  nrmc_pkg::t_result i_data,
    input  logic              i_ready,
    output logic              o_valid,
    output nrmc_pkg::t_result o_data,
    output logic              o_free
);
    import nrmc_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_data;
        end
    end

endmodule
